// ----- hdl/pta_pkg.sv -----
// shared widths, types and the arctangent table for the pan/tilt angle calculator
// no dependencies; imported by pta_sqrt, pta_cordic and pan_tilt_angle_calculator
`default_nettype none

package pta_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ACC_FRAC        = 22;
  localparam int GUARD_BITS      = 24;

  localparam int ANGLE_WIDTH = 17;
  localparam int DIST_WIDTH  = 25;

  // coordinate differences and their magnitudes
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int MAG_WIDTH      = COORD_WIDTH + 1;
  localparam int RADICAND_WIDTH = 2 * MAG_WIDTH;

  // digit-by-digit square root
  localparam int SQRT_STEPS = RADICAND_WIDTH / 2;
  localparam int ROOT_WIDTH = SQRT_STEPS;
  localparam int REM_WIDTH  = ROOT_WIDTH + 1;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  // vectoring unit
  localparam int CIN_WIDTH  = COORD_WIDTH + 3;
  localparam int CW         = CIN_WIDTH + GUARD_BITS + 3;
  localparam int ACC_WIDTH  = 32;
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;

  localparam logic signed [ACC_WIDTH-1:0] ACC_90  = ACC_WIDTH'(90 * (2 ** ACC_FRAC));
  localparam logic signed [ACC_WIDTH-1:0] ACC_180 = ACC_WIDTH'(180 * (2 ** ACC_FRAC));

  localparam int ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(2 ** (ROUND_SH - 1));
  localparam logic signed [ACC_WIDTH-1:0] FULL_TURN  = ACC_WIDTH'(360 * (2 ** ANGLE_FRAC_BITS));

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic [MAG_WIDTH-1:0]         mag_t;
  typedef logic [RADICAND_WIDTH-1:0]    radicand_t;
  typedef logic [ROOT_WIDTH:0]          root_t;
  typedef logic signed [CIN_WIDTH-1:0]  cin_t;
  typedef logic [ANGLE_WIDTH-1:0]       angle_t;
  typedef logic [DIST_WIDTH-1:0]        dist_t;

  // round(atan(2^-i) * 180/pi * 2^22)
  function automatic logic signed [ACC_WIDTH-1:0] atan_entry(input int idx);
    logic signed [ACC_WIDTH-1:0] val;
    case (idx)
      0:       val = 32'sd188743680;
      1:       val = 32'sd111421900;
      2:       val = 32'sd58872272;
      3:       val = 32'sd29884485;
      4:       val = 32'sd15000234;
      5:       val = 32'sd7507429;
      6:       val = 32'sd3754631;
      7:       val = 32'sd1877430;
      8:       val = 32'sd938729;
      9:       val = 32'sd469366;
      10:      val = 32'sd234683;
      11:      val = 32'sd117342;
      12:      val = 32'sd58671;
      13:      val = 32'sd29335;
      14:      val = 32'sd14668;
      15:      val = 32'sd7334;
      16:      val = 32'sd3667;
      17:      val = 32'sd1833;
      18:      val = 32'sd917;
      19:      val = 32'sd458;
      20:      val = 32'sd229;
      21:      val = 32'sd115;
      22:      val = 32'sd57;
      23:      val = 32'sd29;
      24:      val = 32'sd14;
      25:      val = 32'sd7;
      26:      val = 32'sd4;
      27:      val = 32'sd2;
      28:      val = 32'sd1;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pta_sqrt.sv -----
// pipelined rounded square root, one result bit per stage, plus a rounding stage
// depends on pta_pkg; carries dz alongside as sideband
`default_nettype none

module pta_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pta_pkg::radicand_t  radicand,
  input  pta_pkg::diff_t      in_dz,
  output logic                out_valid,
  output pta_pkg::root_t      root,
  output pta_pkg::diff_t      out_dz
);
  import pta_pkg::*;

  logic                  v_r    [SQRT_STEPS];
  logic [REM_WIDTH-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_WIDTH-1:0] root_r [SQRT_STEPS];
  radicand_t             rad_r  [SQRT_STEPS];
  diff_t                 dz_r   [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int K = SQRT_STEPS - 1 - j;
    logic                  v_i;
    logic [REM_WIDTH-1:0]  rem_i;
    logic [ROOT_WIDTH-1:0] root_i;
    radicand_t             rad_i;
    diff_t                 dz_i;
    logic [REM_WIDTH+1:0]  rem_sh;
    logic [REM_WIDTH+1:0]  trial;
    logic [REM_WIDTH-1:0]  rem_n;
    logic [ROOT_WIDTH-1:0] root_n;

    if (j == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = radicand;
      assign dz_i   = in_dz;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign rad_i  = rad_r[j-1];
      assign dz_i   = dz_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_i, rad_i[2*K+1 -: 2]};
      trial  = (REM_WIDTH + 2)'({root_i, 2'b01});
      if (rem_sh >= trial) begin
        rem_n  = REM_WIDTH'(rem_sh - trial);
        root_n = {root_i[ROOT_WIDTH-2:0], 1'b1};
      end else begin
        rem_n  = REM_WIDTH'(rem_sh);
        root_n = {root_i[ROOT_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_n;
        root_r[j] <= root_n;
        rad_r[j]  <= rad_i;
        dz_r[j]   <= dz_i;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_r[SQRT_STEPS-1] > REM_WIDTH'(root_r[SQRT_STEPS-1])) begin
        root <= (ROOT_WIDTH + 1)'(root_r[SQRT_STEPS-1]) + 1'b1;
      end else begin
        root <= (ROOT_WIDTH + 1)'(root_r[SQRT_STEPS-1]);
      end
      out_dz <= dz_r[SQRT_STEPS-1];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pta_cordic.sv -----
// pipelined cordic vectoring unit: atan2(y, x) in degrees, wrapped to [0, 360)
// depends on pta_pkg (widths, arctangent table, rounding constants)
`default_nettype none

module pta_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  pta_pkg::cin_t   in_y,
  input  pta_pkg::cin_t   in_x,
  output logic            out_valid,
  output pta_pkg::angle_t angle
);
  import pta_pkg::*;

  logic                        v_r    [CORDIC_STAGES+1];
  logic                        hold_r [CORDIC_STAGES+1];
  logic signed [CW-1:0]        x_r    [CORDIC_STAGES+1];
  logic signed [CW-1:0]        y_r    [CORDIC_STAGES+1];
  logic signed [ACC_WIDTH-1:0] acc_r  [CORDIC_STAGES+1];

  // prep: axis cases give exact angles, left half-plane turned by 90 degrees
  logic signed [CW-1:0]        xs, ys, x0, y0;
  logic signed [ACC_WIDTH-1:0] acc0;
  logic                        hold0;

  always_comb begin
    xs    = CW'(in_x) <<< GUARD_BITS;
    ys    = CW'(in_y) <<< GUARD_BITS;
    hold0 = (in_y == '0) || (in_x == '0);
    x0    = xs;
    y0    = ys;
    acc0  = '0;
    if (in_y == '0) begin
      acc0 = in_x[CIN_WIDTH-1] ? ACC_180 : '0;
    end else if (in_x == '0) begin
      acc0 = in_y[CIN_WIDTH-1] ? -ACC_90 : ACC_90;
    end else if (in_x[CIN_WIDTH-1]) begin
      if (!in_y[CIN_WIDTH-1]) begin
        x0   = ys;
        y0   = -xs;
        acc0 = ACC_90;
      end else begin
        x0   = -ys;
        y0   = xs;
        acc0 = -ACC_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold_r[0] <= hold0;
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      acc_r[0]  <= acc0;
    end
  end

  // micro-rotations, one per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [ACC_WIDTH-1:0] ANG = atan_entry(i);
    logic signed [CW-1:0]        x_sh, y_sh, x_n, y_n;
    logic signed [ACC_WIDTH-1:0] acc_n;

    always_comb begin
      x_sh = x_r[i] >>> i;
      y_sh = y_r[i] >>> i;
      if (!y_r[i][CW-1]) begin
        x_n   = x_r[i] + y_sh;
        y_n   = y_r[i] - x_sh;
        acc_n = acc_r[i] + ANG;
      end else begin
        x_n   = x_r[i] - y_sh;
        y_n   = y_r[i] + x_sh;
        acc_n = acc_r[i] - ANG;
      end
      if (hold_r[i]) begin
        acc_n = acc_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hold_r[i+1] <= hold_r[i];
        x_r[i+1]    <= x_n;
        y_r[i+1]    <= y_n;
        acc_r[i+1]  <= acc_n;
      end
    end
  end

  // round half up to output fraction bits and wrap into one turn
  logic signed [ACC_WIDTH-1:0] rnd, wrapped;

  always_comb begin
    rnd     = (acc_r[CORDIC_STAGES] + ROUND_HALF) >>> ROUND_SH;
    wrapped = rnd;
    if (rnd < 0) begin
      wrapped = rnd + FULL_TURN;
    end else if (rnd >= FULL_TURN) begin
      wrapped = rnd - FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= wrapped[ANGLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pan_tilt_angle_calculator.sv -----
// top level: pan, tilt and ground distance from tracker and target positions
// depends on pta_pkg, pta_sqrt and pta_cordic
`default_nettype none

// channel   signals                                  direction
// input     in_valid/in_ready, tracker_*, target_*   one position pair per transaction
// output    out_valid/out_ready, pan_deg, tilt_deg,  one result per transaction
//           ground_distance
//
// a new transaction can be taken every cycle while in_ready is high; data pass 4 front
// stages (difference, magnitude, squares, sum), 26 square root stages, 18 stages of the
// tilt cordic and the output register. pan runs on its own cordic and waits in a
// delay line. rst is synchronous and clears only the valid bits.
// the whole pipeline moves on one enable; a result not taken goes to a skid register,
// and the pipeline holds only while that register is full, so in_ready is registered.

module pan_tilt_angle_calculator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] tracker_x,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] tracker_y,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] tracker_z,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] target_x,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] target_y,
  input  logic signed [pta_pkg::COORD_WIDTH-1:0] target_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pta_pkg::angle_t                     pan_deg,
  output pta_pkg::angle_t                     tilt_deg,
  output pta_pkg::dist_t                      ground_distance
);
  import pta_pkg::*;

  localparam int PAN_DLY = 3 + SQRT_LAT;

  logic en;
  logic skid_v;

  assign en       = !skid_v;
  assign in_ready = en;

  // stage 1: differences, target minus tracker
  logic  s1_v;
  diff_t s1_dx, s1_dy, s1_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx <= DIFF_WIDTH'(target_x) - DIFF_WIDTH'(tracker_x);
      s1_dy <= DIFF_WIDTH'(target_y) - DIFF_WIDTH'(tracker_y);
      s1_dz <= DIFF_WIDTH'(target_z) - DIFF_WIDTH'(tracker_z);
    end
  end

  // stage 2: magnitudes
  logic  s2_v;
  mag_t  s2_ax, s2_ay;
  diff_t s2_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax <= s1_dx[DIFF_WIDTH-1] ? MAG_WIDTH'(-s1_dx) : MAG_WIDTH'(s1_dx);
      s2_ay <= s1_dy[DIFF_WIDTH-1] ? MAG_WIDTH'(-s1_dy) : MAG_WIDTH'(s1_dy);
      s2_dz <= s1_dz;
    end
  end

  // stage 3: squares
  logic      s3_v;
  radicand_t s3_sx, s3_sy;
  diff_t     s3_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sx <= RADICAND_WIDTH'(s2_ax) * RADICAND_WIDTH'(s2_ax);
      s3_sy <= RADICAND_WIDTH'(s2_ay) * RADICAND_WIDTH'(s2_ay);
      s3_dz <= s2_dz;
    end
  end

  // stage 4: sum of squares, cannot overflow the radicand width
  logic      s4_v;
  radicand_t s4_sum;
  diff_t     s4_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum <= s3_sx + s3_sy;
      s4_dz  <= s3_dz;
    end
  end

  // rounded horizontal distance
  logic  sq_v;
  root_t sq_root;
  diff_t sq_dz;

  pta_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .radicand  (s4_sum),
    .in_dz     (s4_dz),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_dz    (sq_dz)
  );

  // pan cordic on dx, dy
  logic   pan_v;
  angle_t pan_result;

  pta_cordic u_pan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_v),
    .in_y      (CIN_WIDTH'(s1_dy)),
    .in_x      (CIN_WIDTH'(s1_dx)),
    .out_valid (pan_v),
    .angle     (pan_result)
  );

  // tilt cordic on dz against the unsaturated distance
  logic   tilt_v;
  angle_t tilt_result;

  pta_cordic u_tilt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .in_y      (CIN_WIDTH'(sq_dz)),
    .in_x      (signed'(CIN_WIDTH'(sq_root))),
    .out_valid (tilt_v),
    .angle     (tilt_result)
  );

  // pan waits for the square root and tilt paths
  logic   pan_dly_v [PAN_DLY];
  angle_t pan_dly   [PAN_DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PAN_DLY; k++) begin
        pan_dly_v[k] <= 1'b0;
      end
    end else if (en) begin
      pan_dly_v[0] <= pan_v;
      for (int k = 1; k < PAN_DLY; k++) begin
        pan_dly_v[k] <= pan_dly_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pan_dly[0] <= pan_result;
      for (int k = 1; k < PAN_DLY; k++) begin
        pan_dly[k] <= pan_dly[k-1];
      end
    end
  end

  // saturated distance rides beside the tilt cordic
  dist_t dist_sat;
  dist_t dist_dly [CORDIC_LAT];

  assign dist_sat = (sq_root > (ROOT_WIDTH + 1)'(DIST_MAX)) ? DIST_MAX
                                                            : sq_root[DIST_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_dly[0] <= dist_sat;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        dist_dly[k] <= dist_dly[k-1];
      end
    end
  end

  // output register plus skid register
  angle_t skid_pan, skid_tilt;
  dist_t  skid_dist;
  logic   last_v;

  assign last_v = en && tilt_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= last_v;
      end
    end else if (last_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_v) begin
        pan_deg         <= skid_pan;
        tilt_deg        <= skid_tilt;
        ground_distance <= skid_dist;
      end else if (last_v) begin
        pan_deg         <= pan_dly[PAN_DLY-1];
        tilt_deg        <= tilt_result;
        ground_distance <= dist_dly[CORDIC_LAT-1];
      end
    end else if (last_v) begin
      skid_pan  <= pan_dly[PAN_DLY-1];
      skid_tilt <= tilt_result;
      skid_dist <= dist_dly[CORDIC_LAT-1];
    end
  end

`ifndef SYNTH
  // pan delay line and tilt path stay in step
  assert property (@(posedge clk) disable iff (rst) pan_dly_v[PAN_DLY-1] == tilt_v)
    else $error("pan and tilt paths out of step");

  // skid register holds a result only behind a held output
  assert property (@(posedge clk) disable iff (rst) skid_v |-> out_valid)
    else $error("skid full with output empty");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready))
    else $error("skid filled while output was free");

  // angles stay within one turn
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pan_deg < ANGLE_WIDTH'(FULL_TURN)) && (tilt_deg < ANGLE_WIDTH'(FULL_TURN)))
    else $error("angle outside one turn");
`endif

endmodule

`default_nettype wire
